// File: sv/vrap_pkg.sv
package vrap_pkg;

    localparam int unsigned VRAM_AW = 14;

    typedef enum logic [1:0] {
        OP_SCROLL  = 2'd0,
        OP_ADDRESS = 2'd1,
        OP_WRITE   = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    // One incoming bus access
    typedef struct packed {
        op_t        operation;
        logic [7:0] data_byte;
    } req_t;

    // One result beat
    typedef struct packed {
        logic [7:0]         read_data;
        logic [VRAM_AW-1:0] mem_address;
    } rslt_t;

    // Access handed from the register stage to the memory stage
    typedef struct packed {
        logic               valid;
        op_t                op;
        logic [7:0]         data_byte;
        logic [VRAM_AW-1:0] addr;
    } acc_t;

    localparam logic [VRAM_AW-1:0] NT_MIRROR_LO = 14'h3000;
    localparam logic [VRAM_AW-1:0] PAL_BASE     = 14'h3F00;
    localparam logic [VRAM_AW-1:0] PAL_END      = 14'h3F20;
    localparam logic [VRAM_AW-1:0] NT_MIRROR_OF = 14'h1000;

endpackage

// File: sv/vrap_regs.sv
module vrap_regs
    import vrap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  req_t req,
    output acc_t acc
);

    logic [15:0]        access_address_reg, access_address_next;
    logic [15:0]        scroll_latch_reg, scroll_latch_next;
    logic               second_write_reg, second_write_next;
    logic               acc_valid_reg;
    op_t                acc_op_reg;
    logic [7:0]         acc_byte_reg;
    logic [VRAM_AW-1:0] acc_addr_reg;
    logic [VRAM_AW-1:0] raw_addr;
    logic [VRAM_AW-1:0] mirrored;
    logic               is_data;

    assign raw_addr = access_address_reg[VRAM_AW-1:0];
    assign is_data  = (req.operation == OP_WRITE) || (req.operation == OP_READ);

    always_comb
    begin
        priority if (raw_addr < NT_MIRROR_LO)
        begin
            mirrored = raw_addr;
        end
        else if (raw_addr < PAL_BASE)
        begin
            mirrored = raw_addr - NT_MIRROR_OF;
        end
        else if (raw_addr < PAL_END)
        begin
            mirrored = raw_addr;
        end
        else
        begin
            // fold onto the 32-byte palette
            mirrored = PAL_BASE | {9'd0, raw_addr[4:0]};
        end
    end

    always_comb
    begin
        access_address_next = access_address_reg;
        scroll_latch_next   = scroll_latch_reg;
        second_write_next   = second_write_reg;
        if (accept)
        begin
            unique case (req.operation)
                OP_SCROLL:
                begin
                    scroll_latch_next = second_write_reg
                        ? {scroll_latch_reg[15:8], req.data_byte}
                        : {req.data_byte, scroll_latch_reg[7:0]};
                    second_write_next = ~second_write_reg;
                end
                OP_ADDRESS:
                begin
                    access_address_next = second_write_reg
                        ? {access_address_reg[15:8], req.data_byte}
                        : {req.data_byte, access_address_reg[7:0]};
                    second_write_next = ~second_write_reg;
                end
                default:
                begin
                    access_address_next = access_address_reg + 16'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_address_reg <= '0;
            scroll_latch_reg   <= '0;
            second_write_reg   <= 1'b0;
            acc_valid_reg      <= 1'b0;
        end
        else
        begin
            access_address_reg <= access_address_next;
            scroll_latch_reg   <= scroll_latch_next;
            second_write_reg   <= second_write_next;
            acc_valid_reg      <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_op_reg   <= req.operation;
            acc_byte_reg <= req.data_byte;
            acc_addr_reg <= is_data ? mirrored : '0;
        end
    end

    assign acc.valid     = acc_valid_reg;
    assign acc.op        = acc_op_reg;
    assign acc.data_byte = acc_byte_reg;
    assign acc.addr      = acc_addr_reg;

    a_data_keeps_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_data |=> $stable(second_write_reg))
        else $error("data access disturbed the write toggle");

    a_latch_flips_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_data |=> second_write_reg != $past(second_write_reg))
        else $error("latch write did not flip the toggle");

    a_no_unmirrored: assert property (@(posedge clk) disable iff (!rst_n)
        acc_valid_reg |-> !(acc_addr_reg >= NT_MIRROR_LO && acc_addr_reg < PAL_BASE))
        else $error("address reached memory unmirrored");

endmodule

// File: sv/vrap_mem.sv
module vrap_mem
    import vrap_pkg::*;
#(
    parameter int unsigned MEM_DEPTH = 16384
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  acc_t  acc,
    output logic  done,
    output rslt_t result
);

    localparam int unsigned IDX_W = $clog2(MEM_DEPTH);

    logic [7:0]         vram [MEM_DEPTH];
    logic [7:0]         rdata_reg;
    logic               done_reg;
    logic               is_read_reg;
    logic [VRAM_AW-1:0] addr_reg;
    logic [IDX_W-1:0]   idx;

    assign idx = acc.addr[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (acc.valid && acc.op == OP_WRITE)
        begin
            vram[idx] <= acc.data_byte;
        end
        rdata_reg <= vram[idx];
        if (acc.valid)
        begin
            is_read_reg <= (acc.op == OP_READ);
            addr_reg    <= acc.addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= acc.valid;
        end
    end

    assign done               = done_reg;
    assign result.read_data   = is_read_reg ? rdata_reg : 8'd0;
    assign result.mem_address = addr_reg;

    a_non_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !is_read_reg |-> result.read_data == 8'd0)
        else $error("non-read beat carried read data");

endmodule

// File: sv/video_ram_access_port_unit.sv
// CPU-side access port of a video processor. Each start pulse carries one bus
// access: scroll write, address write, data write or data read. Busy stays low,
// so an access may be issued every clock cycle; its result appears on result,
// marked by done, and holds for one cycle only, since the receiver cannot stall.
// Each access passes through the register stage (address latch, toggle and
// mirroring) and then the single-port 16 KiB video memory, whose read data is
// registered. Reading a memory location never written returns an arbitrary byte.
module video_ram_access_port_unit
    import vrap_pkg::*;
#(
    parameter int unsigned MEM_DEPTH = 16384
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  req_t  request,
    output logic  done,
    output rslt_t result
);

    logic accept;
    acc_t acc;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    vrap_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (request),
        .acc    (acc)
    );

    vrap_mem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc    (acc),
        .done   (done),
        .result (result)
    );

    a_beat_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted beat produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ##1 !done)
        else $error("result without an accepted beat");

endmodule
